[hdl/ogf_pkg.sv]
package ogf_pkg;

    // Field widths of the result item and of the configuration registers.
    localparam int COL_W  = 5;
    localparam int ROW_W  = 10;
    localparam int WCFG_W = 6;
    localparam int HCFG_W = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Result queue: up to three results are pushed for one input item.
    localparam int PUSH_SLOTS = 3;
    localparam int QDEPTH     = 8;
    localparam int PTR_W      = $clog2(QDEPTH);
    localparam int CNT_W      = $clog2(QDEPTH + 1);

    // Map codes carried in map_select.
    localparam logic MAP_FILLED = 1'b0;
    localparam logic MAP_POOLED = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic map_select;
        logic cell_blocked;
        col_t column;
        row_t row;
        logic last;
    } res_t;

    // Broadcast from the control logic to every cell of the chain.
    typedef struct packed {
        logic fire;
        logic blocked;
        logic win_en;
        logic row_end;
        logic orig_we;
    } cell_ctl_t;

    // Fill requests that a cell hands to its left neighbor.
    typedef struct packed {
        logic set_up;
        logic set_lo;
    } nbr_t;

    // Per-cell read taps, nonzero only in the selected cell.
    typedef struct packed {
        logic up_left_fin;
        logic up_here_fin;
        logic orig_here;
        logic flush_lo;
    } cell_tap_t;

endpackage

[hdl/ogf_cell.sv]
module ogf_cell (
    input  logic               aclk,
    input  ogf_pkg::cell_ctl_t ctl,
    input  logic               here,
    input  logic               flush_here,
    input  logic               left_up,
    input  logic               left_lo,
    input  ogf_pkg::nbr_t      from_right,
    output ogf_pkg::nbr_t      to_left,
    output logic               up_q,
    output logic               lo_q,
    output ogf_pkg::cell_tap_t tap
);
    import ogf_pkg::*;

    // One column of the grid: the filled value of the row above, the filled
    // value of the current row and the original value of the last even row.
    logic up_reg, up_next;
    logic lo_reg, lo_next;
    logic orig_reg, orig_next;
    logic p1, p2;
    logic lo_new, up_new;

    // The window's top-left and bottom-left come from the left neighbor.
    assign p1 = ctl.win_en & here & left_up & ~up_reg & ~left_lo & ctl.blocked;
    assign p2 = ctl.win_en & here & ~left_up & up_reg & left_lo & ~ctl.blocked;

    assign to_left.set_lo = p1;
    assign to_left.set_up = p2;

    always_comb begin
        lo_new    = here ? (ctl.blocked | p2) : (lo_reg | from_right.set_lo);
        up_new    = up_reg | p1 | from_right.set_up;
        lo_next   = lo_reg;
        up_next   = up_reg;
        orig_next = orig_reg;
        if (ctl.fire) begin
            lo_next = lo_new;
            // At the end of a row the current row becomes the row above.
            up_next = ctl.row_end ? lo_new : up_new;
            if (here && ctl.orig_we) begin
                orig_next = ctl.blocked;
            end
        end
    end

    always_ff @(posedge aclk) begin
        up_reg   <= up_next;
        lo_reg   <= lo_next;
        orig_reg <= orig_next;
    end

    assign up_q = up_reg;
    assign lo_q = lo_reg;

    assign tap.up_left_fin = here & ctl.win_en & (left_up | p2);
    assign tap.up_here_fin = here & (up_reg | p1);
    assign tap.orig_here   = here & orig_reg;
    assign tap.flush_lo    = flush_here & lo_reg;

endmodule

[hdl/ogf_out_queue.sv]
module ogf_out_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ogf_pkg::PUSH_SLOTS-1:0]   push_vld,
    input  ogf_pkg::res_t                    push_data [ogf_pkg::PUSH_SLOTS],
    input  logic                             pop,
    output logic [ogf_pkg::CNT_W-1:0]        count,
    output ogf_pkg::res_t                    head
);
    import ogf_pkg::*;

    res_t             mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] slot_addr [PUSH_SLOTS];
    logic [CNT_W-1:0] push_cnt;

    // Valid slots are packed in order behind the write pointer.
    always_comb begin
        push_cnt = '0;
        for (int k = 0; k < PUSH_SLOTS; k++) begin
            slot_addr[k] = wr_ptr_reg + PTR_W'(push_cnt);
            push_cnt     = push_cnt + CNT_W'(push_vld[k]);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PUSH_SLOTS; k++) begin
            if (push_vld[k]) begin
                mem[slot_addr[k]] <= push_data[k];
            end
        end
    end

    assign count = count_reg;
    assign head  = mem[rd_ptr_reg];

endmodule

[hdl/occupancy_grid_gap_fill_and_pool.sv]
// Occupancy grid gap filler and 2x2 pooler. Cells of a binary grid arrive
// one per item in raster order on the s_ channel; results leave on the m_
// channel, each tagged with its map (filled or half-size), column, row and a
// last flag on the final result caused by an input item. The grid's width and
// height are set through the APB port (width at address 0, height at address
// 4); the user must write them only while the block is idle, as the block does
// not enforce it. An input item is taken while no last-row readout runs and
// the result queue has room for three more results, so the block runs at one
// item per cycle as long as the downstream side keeps up; the sustained rate
// is set by the single result port, which moves one result per cycle, and
// most items of an odd row cause one or two results. At the last cell of a
// grid the whole last row is read out of the cell chain, one cell per cycle
// while the queue has room, then any pooled result; input waits for both and
// for the queue to drain back to room for three results. There is no clearing
// pass after reset: line storage is undefined until written by the first rows.
module occupancy_grid_gap_fill_and_pool #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_blocked,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_map_select,
    output logic                         m_cell_blocked,
    output ogf_pkg::col_t                m_column,
    output ogf_pkg::row_t                m_row,
    output logic                         m_last,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ogf_pkg::ADDR_W-1:0]   paddr,
    input  logic [ogf_pkg::DATA_W-1:0]   pwdata,
    output logic [ogf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import ogf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [WCFG_W-1:0] WMAX = WCFG_W'(MAX_WIDTH);

    // Sequencer states: normal streaming, last-row readout, trailing pool.
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_POOL  = 2'd2;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [WCFG_W-1:0] width_reg, width_next;
    logic [HCFG_W-1:0] height_reg, height_next;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (paddr[2])
                REG_GRID_WIDTH:  width_next  = pwdata[WCFG_W-1:0];
                REG_GRID_HEIGHT: height_next = pwdata[HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = DATA_W'(width_reg);
            REG_GRID_HEIGHT: prdata = DATA_W'(height_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Position tracking. Out-of-range sizes are saturated to the legal
    // range; a row ends at the first column at or past the last column, so
    // a size change in mid-grid keeps the current position.
    // ------------------------------------------------------------------
    logic [CW-1:0]     col_reg, col_next;
    row_t              row_reg, row_next;
    logic              pool_partial_reg, pool_partial_next;
    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     flush_col_reg, flush_col_next;
    logic [CW-1:0]     flush_end_reg, flush_end_next;
    row_t              flush_row_reg, flush_row_next;
    logic              pend_vld_reg, pend_vld_next;
    res_t              pend_reg, pend_next;

    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic              row_end, grid_end, fire, win_en;
    logic [CW-1:0]     col_m1;
    logic [CNT_W-1:0]  q_count;
    logic              q_room;
    logic              flush_at_end;

    always_comb begin
        if (width_reg < WCFG_W'(2)) begin
            w_eff = WCFG_W'(2);
        end else if (width_reg > WMAX) begin
            w_eff = WMAX;
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HCFG_W'(2)) ? HCFG_W'(2) : height_reg;
    end

    assign row_end  = WCFG_W'(col_reg) >= (w_eff - WCFG_W'(1));
    assign grid_end = row_end && (row_reg >= (h_eff - HCFG_W'(1)));
    assign s_ready  = (state_reg == ST_RUN) && (q_count <= CNT_W'(QDEPTH - PUSH_SLOTS));
    assign fire     = s_valid & s_ready;
    assign win_en   = (row_reg != '0) && (col_reg != '0);
    assign col_m1   = col_reg - CW'(1);
    assign q_room   = q_count < CNT_W'(QDEPTH);
    assign flush_at_end = flush_col_reg == flush_end_reg;

    // ------------------------------------------------------------------
    // Cell chain. Cell i holds column i. The selected cell evaluates the
    // 2x2 window with the values handed over by its left neighbor and
    // hands its fill requests back to that neighbor.
    // ------------------------------------------------------------------
    cell_ctl_t ctl;
    logic      up_q       [MAX_WIDTH];
    logic      lo_q       [MAX_WIDTH];
    logic      left_up_w  [MAX_WIDTH];
    logic      left_lo_w  [MAX_WIDTH];
    nbr_t      to_left    [MAX_WIDTH];
    nbr_t      from_right [MAX_WIDTH];
    cell_tap_t tap        [MAX_WIDTH];

    assign ctl.fire    = fire;
    assign ctl.blocked = s_blocked;
    assign ctl.win_en  = win_en;
    assign ctl.row_end = row_end;
    assign ctl.orig_we = ~row_reg[0];

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_up_w[i] = 1'b0;
            assign left_lo_w[i] = 1'b0;
        end else begin : g_inner
            assign left_up_w[i] = up_q[i-1];
            assign left_lo_w[i] = lo_q[i-1];
        end
        if (i == MAX_WIDTH - 1) begin : g_last
            assign from_right[i] = '0;
        end else begin : g_mid
            assign from_right[i] = to_left[i+1];
        end

        ogf_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .here       (col_reg == CW'(i)),
            .flush_here ((state_reg == ST_FLUSH) && (flush_col_reg == CW'(i))),
            .left_up    (left_up_w[i]),
            .left_lo    (left_lo_w[i]),
            .from_right (from_right[i]),
            .to_left    (to_left[i]),
            .up_q       (up_q[i]),
            .lo_q       (lo_q[i]),
            .tap        (tap[i])
        );
    end

    // Only the selected cell drives its taps, so an OR gathers them.
    cell_tap_t tap_any;

    always_comb begin
        tap_any = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            tap_any = tap_any | tap[i];
        end
    end

    // ------------------------------------------------------------------
    // Results of one item, in order: the finished cell of the row above,
    // the row above's last cell at a row end, and the pooled cell. At the
    // end of a grid the pooled cell waits until the last row is read out.
    // ------------------------------------------------------------------
    logic [PUSH_SLOTS-1:0] step_vld, push_vld;
    res_t                  step_res [PUSH_SLOTS];
    res_t                  push_data [PUSH_SLOTS];
    logic                  pool_val, pool_here;
    res_t                  pool_res, flush_res, head;

    assign pool_here = row_reg[0] & col_reg[0];
    assign pool_val  = pool_partial_reg | tap_any.orig_here | s_blocked;

    always_comb begin
        pool_res.map_select   = MAP_POOLED;
        pool_res.cell_blocked = pool_val;
        pool_res.column       = col_t'(col_reg >> 1);
        pool_res.row          = row_reg >> 1;
        pool_res.last         = 1'b1;

        step_vld[0] = win_en;
        step_vld[1] = (row_reg != '0) && row_end;
        step_vld[2] = pool_here && !grid_end;

        step_res[0].map_select   = MAP_FILLED;
        step_res[0].cell_blocked = tap_any.up_left_fin;
        step_res[0].column       = col_t'(col_m1);
        step_res[0].row          = row_reg - ROW_W'(1);
        step_res[0].last         = step_vld[0] & ~step_vld[1] & ~step_vld[2] & ~grid_end;

        step_res[1].map_select   = MAP_FILLED;
        step_res[1].cell_blocked = tap_any.up_here_fin;
        step_res[1].column       = col_t'(col_reg);
        step_res[1].row          = row_reg - ROW_W'(1);
        step_res[1].last         = step_vld[1] & ~step_vld[2] & ~grid_end;

        step_res[2]      = pool_res;
        step_res[2].last = step_vld[2];

        flush_res.map_select   = MAP_FILLED;
        flush_res.cell_blocked = tap_any.flush_lo;
        flush_res.column       = col_t'(flush_col_reg);
        flush_res.row          = flush_row_reg;
        flush_res.last         = flush_at_end & ~pend_vld_reg;
    end

    always_comb begin
        push_vld  = '0;
        push_data = step_res;
        case (state_reg)
            ST_RUN: begin
                push_vld = fire ? step_vld : '0;
            end
            ST_FLUSH: begin
                push_vld[0]  = q_room;
                push_data[0] = flush_res;
            end
            ST_POOL: begin
                push_vld[0]  = q_room;
                push_data[0] = pend_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and counters.
    // ------------------------------------------------------------------
    always_comb begin
        col_next          = col_reg;
        row_next          = row_reg;
        pool_partial_next = pool_partial_reg;
        state_next        = state_reg;
        flush_col_next    = flush_col_reg;
        flush_end_next    = flush_end_reg;
        flush_row_next    = flush_row_reg;
        pend_vld_next     = pend_vld_reg;
        pend_next         = pend_reg;

        if (fire) begin
            // The row count moves only at the end of a row.
            if (row_end) begin
                col_next = '0;
                row_next = grid_end ? '0 : (row_reg + ROW_W'(1));
            end else begin
                col_next = col_reg + CW'(1);
            end
            if (row_reg[0] && !col_reg[0]) begin
                pool_partial_next = tap_any.orig_here | s_blocked;
            end
        end

        case (state_reg)
            ST_RUN: begin
                if (fire && grid_end) begin
                    state_next     = ST_FLUSH;
                    flush_col_next = '0;
                    flush_end_next = col_reg;
                    flush_row_next = row_reg;
                    pend_vld_next  = pool_here;
                    pend_next      = pool_res;
                end
            end
            ST_FLUSH: begin
                if (q_room) begin
                    if (flush_at_end) begin
                        state_next = pend_vld_reg ? ST_POOL : ST_RUN;
                    end else begin
                        flush_col_next = flush_col_reg + CW'(1);
                    end
                end
            end
            ST_POOL: begin
                if (q_room) begin
                    state_next    = ST_RUN;
                    pend_vld_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= WCFG_W'(32);
            height_reg       <= HCFG_W'(32);
            col_reg          <= '0;
            row_reg          <= '0;
            pool_partial_reg <= 1'b0;
            state_reg        <= ST_RUN;
            flush_col_reg    <= '0;
            flush_end_reg    <= '0;
            pend_vld_reg     <= 1'b0;
        end else begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            pool_partial_reg <= pool_partial_next;
            state_reg        <= state_next;
            flush_col_reg    <= flush_col_next;
            flush_end_reg    <= flush_end_next;
            pend_vld_reg     <= pend_vld_next;
        end
    end

    // Payload of the pending readout needs no reset.
    always_ff @(posedge aclk) begin
        flush_row_reg <= flush_row_next;
        pend_reg      <= pend_next;
    end

    // ------------------------------------------------------------------
    // Result queue: decouples the input side from the result port.
    // ------------------------------------------------------------------
    ogf_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_vld  (push_vld),
        .push_data (push_data),
        .pop       (m_valid & m_ready),
        .count     (q_count),
        .head      (head)
    );

    assign m_valid        = q_count != '0;
    assign m_map_select   = head.map_select;
    assign m_cell_blocked = head.cell_blocked;
    assign m_column       = head.column;
    assign m_row          = head.row;
    assign m_last         = head.last;

endmodule

[tb/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ogf_pkg::*;

    // The block keeps one line of cells per buffer, so the widest grid is 32.
    localparam int MAX_W = 32;

    // Cycles allowed for an item that causes no result to leave the block.
    localparam int SETTLE_CYCLES = 16;

    // Length of the one long stretch in which the result side refuses items.
    localparam int HOLD_CYCLES = 300;

    // Rough stop point for the random part, counted in accepted cells.
    localparam int ITEM_GOAL = 330;

    // Hard stop for a hung run, in clock cycles.
    localparam int LIMIT_CYCLES = 1_000_000;

    // How the cells of one grid are drawn. Sparse grids leave isolated
    // diagonal pairs, dense grids exercise pooling of mostly blocked blocks,
    // and the noisy checkerboard makes long chains of fills in which each
    // window sees the fills of the windows before it.
    typedef enum logic [1:0] {
        PAT_HALF,
        PAT_SPARSE,
        PAT_DENSE,
        PAT_CHECKER
    } pattern_t;

    // One row of the directed plan is either a size setting or a cell.
    typedef enum logic {
        STEP_CONFIG,
        STEP_CELL
    } step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        logic [WCFG_W-1:0]   width;
        logic [HCFG_W-1:0]   height;
        logic                blk;
        logic                pinned;    // pooled value of this cell is typed in
        logic                pool_val;
    } plan_step_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_blocked;
    logic               m_valid;
    logic               m_ready;
    logic               m_map_select;
    logic               m_cell_blocked;
    col_t               m_column;
    row_t               m_row;
    logic               m_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    occupancy_grid_gap_fill_and_pool #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_blocked      (s_blocked),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_map_select   (m_map_select),
        .m_cell_blocked (m_cell_blocked),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last         (m_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Mirror of the block's state, kept by the predictor below.
    bit [MAX_W-1:0]     filled_above;   // filled values of the previous row
    bit [MAX_W-1:0]     filled_here;    // filled values of the current row
    bit [MAX_W-1:0]     orig_even_row;  // unfilled values of the last even row
    bit                 pool_left;      // OR of the left half of a pool block
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [WCFG_W-1:0]  width_reg;
    logic [HCFG_W-1:0]  height_reg;

    // Results the block still owes, oldest first.
    res_t               cells_due[$];

    // Knobs shared between the sender and the receiver.
    bit                 tx_lazy;
    bit                 rx_lazy;
    bit                 hold_req;
    pattern_t           pattern;

    int unsigned        fail_count;
    int unsigned        items_sent;
    int unsigned        reg_writes;
    int unsigned        fills_seen;
    int unsigned        filled_checked;
    int unsigned        pooled_checked;

    // The directed plan. Both diagonals are filled on a 2x2 grid, then the
    // size registers are driven below their legal range so that they
    // saturate to 2x2, and pooling of all-blocked and all-free blocks is
    // pinned to values that need no working out.
    plan_step_t directed_plan [23] = '{
        '{STEP_CONFIG, 6'd2, 10'd2, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b1, 1'b1},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b1, 1'b1},
        '{STEP_CONFIG, 6'd0, 10'd1, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b1, 1'b1},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b1, 1'b0},
        '{STEP_CONFIG, 6'd1, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b0, 1'b0, 1'b0},
        '{STEP_CELL,   6'd0, 10'd0, 1'b1, 1'b1, 1'b1}
    };

    // The block saturates both sizes into their legal ranges.
    function automatic int unsigned clamp_width(logic [WCFG_W-1:0] raw);
        if (raw < 2) begin
            return 2;
        end
        return (raw > MAX_W) ? MAX_W : raw;
    endfunction

    function automatic int unsigned clamp_height(logic [HCFG_W-1:0] raw);
        return (raw < 2) ? 2 : raw;
    endfunction

    function automatic res_t cell_result(logic sel, logic val, int unsigned col,
                                         int unsigned row);
        res_t res;
        res.map_select   = sel;
        res.cell_blocked = val;
        res.column       = col_t'(col);
        res.row          = row_t'(row);
        res.last         = 1'b0;
        return res;
    endfunction

    // Adds one result at the end of a list of owed results.
    function automatic void append_res(ref res_t due_list[$], input res_t item);
        due_list = {due_list, item};
    endfunction

    // Works out every result that one accepted cell causes and queues them.
    // The window whose lower-right corner is the new cell is applied first;
    // that makes the cell above-left final. A row end also makes the cell
    // straight above final, and the grid end flushes the whole current row.
    // Pooled cells come last, at the lower-right cell of each 2x2 block.
    function automatic void predict_cell(logic blk);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          tl;
        bit          tr;
        bit          bl;
        bit          br;
        bit          row_done;
        bit          grid_done;
        res_t        outs[$];

        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        r = row_pos;

        filled_here[c] = blk;

        if (r >= 1 && c >= 1) begin
            tl = filled_above[c-1];
            tr = filled_above[c];
            bl = filled_here[c-1];
            br = filled_here[c];
            if (tl && !tr && !bl && br) begin
                filled_above[c]  = 1'b1;
                filled_here[c-1] = 1'b1;
                fills_seen++;
            end else if (!tl && tr && bl && !br) begin
                filled_above[c-1] = 1'b1;
                filled_here[c]    = 1'b1;
                fills_seen++;
            end
            append_res(outs, cell_result(MAP_FILLED, filled_above[c-1], c - 1, r - 1));
        end

        row_done  = (c >= w - 1);
        grid_done = row_done && (r >= h - 1);

        if (r >= 1 && row_done) begin
            append_res(outs, cell_result(MAP_FILLED, filled_above[c], c, r - 1));
        end

        if (grid_done) begin
            for (int unsigned i = 0; i <= c; i++) begin
                append_res(outs, cell_result(MAP_FILLED, filled_here[i], i, r));
            end
        end

        if (r % 2 == 1) begin
            if (c % 2 == 0) begin
                pool_left = orig_even_row[c] | blk;
            end else begin
                append_res(outs, cell_result(MAP_POOLED,
                                             pool_left | orig_even_row[c] | blk,
                                             c / 2, r / 2));
            end
        end else begin
            orig_even_row[c] = blk;
        end

        if (outs.size() > 0) begin
            outs[outs.size()-1].last = 1'b1;
        end
        foreach (outs[i]) begin
            append_res(cells_due, outs[i]);
        end

        if (row_done) begin
            filled_above = filled_here;
            col_pos      = 0;
            row_pos      = grid_done ? 0 : (r + 1) % 1024;
        end else begin
            col_pos = (c + 1) % MAX_W;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compares the result on the output port with the oldest one owed.
    task automatic check_result();
        res_t want;
        if (cells_due.size() == 0) begin
            $error("result with nothing expected: map %0d col %0d row %0d",
                   m_map_select, m_column, m_row);
            fail_count++;
        end else begin
            want = cells_due.pop_front();
            check_field("map_select", 16'(want.map_select), 16'(m_map_select));
            check_field("cell_blocked", 16'(want.cell_blocked), 16'(m_cell_blocked));
            check_field("column", 16'(want.column), 16'(m_column));
            check_field("row", 16'(want.row), 16'(m_row));
            check_field("last", 16'(want.last), 16'(m_last));
            if (want.map_select == MAP_POOLED) begin
                pooled_checked++;
            end else begin
                filled_checked++;
            end
        end
    endtask

    // All stimulus tasks start and end right after a falling edge, so every
    // input changes there and never twice in the same time step.
    task automatic send_cell(logic blk, logic pinned, logic pool_val);
        int unsigned gap;
        gap = tx_lazy ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_blocked <= blk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_cell(blk);
        // A pinned directed row replaces the worked-out pooled value with the
        // one typed into the plan.
        if (pinned && cells_due.size() > 0 &&
            cells_due[cells_due.size()-1].map_select == MAP_POOLED) begin
            cells_due[cells_due.size()-1].cell_blocked = pool_val;
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Stops offering cells and waits until the block owes nothing. Cells that
    // cause no result may still be inside the block, hence the extra cycles.
    task automatic settle();
        s_valid <= 1'b0;
        while (cells_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(logic index, logic [DATA_W-1:0] value);
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (index == REG_GRID_WIDTH) begin
            width_reg = value[WCFG_W-1:0];
        end else begin
            height_reg = value[HCFG_W-1:0];
        end
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [WCFG_W-1:0] w, logic [HCFG_W-1:0] h);
        settle();
        apb_write(REG_GRID_WIDTH, DATA_W'(w));
        apb_write(REG_GRID_HEIGHT, DATA_W'(h));
    endtask

    function automatic logic cell_value(int unsigned x, int unsigned y);
        case (pattern)
            PAT_SPARSE:  return ($urandom_range(0, 5) == 0);
            PAT_DENSE:   return ($urandom_range(0, 5) != 0);
            PAT_CHECKER: return ((x + y) % 2 == 1) ^ ($urandom_range(0, 7) == 0);
            default:     return $urandom_range(0, 1);
        endcase
    endfunction

    // Picks a cell pattern and how eagerly each side moves items, per grid.
    // Each side runs with no idling in roughly a quarter of the grids.
    function automatic void shuffle_grid_style();
        pattern = pattern_t'($urandom_range(0, 3));
        tx_lazy = ($urandom_range(0, 3) != 0);
        rx_lazy = ($urandom_range(0, 3) != 0);
    endfunction

    task automatic feed_rows(int unsigned w, int unsigned first_row, int unsigned rows);
        for (int unsigned y = first_row; y < first_row + rows; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                send_cell(cell_value(x, y), 1'b0, 1'b0);
            end
        end
    endtask

    task automatic run_grid(int unsigned w, int unsigned h);
        shuffle_grid_style();
        feed_rows(w, 0, h);
    endtask

    // Result side: a random stall before each result, and once, on request,
    // a long refusal so that the block's queue fills and it stalls its input.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_lazy ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_result();
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("occupancy_grid_gap_fill_and_pool regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned w;
        int unsigned h;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_blocked = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        filled_above  = '0;
        filled_here   = '0;
        orig_even_row = '0;
        pool_left     = 1'b0;
        col_pos       = 0;
        row_pos       = 0;
        width_reg     = WCFG_W'(32);
        height_reg    = HCFG_W'(32);
        hold_req      = 1'b0;
        tx_lazy       = 1'b1;
        rx_lazy       = 1'b1;
        pattern       = PAT_HALF;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: walk the plan. Size rows wait for the block to go
        // quiet before the registers are written.
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == STEP_CONFIG) begin
                configure(directed_plan[i].width, directed_plan[i].height);
                tx_lazy = ($urandom_range(0, 1) == 1);
                rx_lazy = ($urandom_range(0, 1) == 1);
            end else begin
                send_cell(directed_plan[i].blk, directed_plan[i].pinned,
                          directed_plan[i].pool_val);
            end
        end

        // A width register far above the limit saturates to the widest grid.
        // The flush at its last cell owes a full row of results at once.
        configure(6'd63, 10'd2);
        run_grid(clamp_width(6'd63), 2);

        // The tallest setting. Rather than feed a thousand rows, the height
        // is lowered while the grid is part way down, which ends the grid at
        // the next row end. Only the height changes, so every line entry the
        // block reads has been written in this grid.
        configure(6'd2, 10'd1023);
        shuffle_grid_style();
        feed_rows(2, 0, 8);
        settle();
        apb_write(REG_GRID_HEIGHT, DATA_W'(3));
        feed_rows(2, 8, 1);

        // Full-width grid with the long refusal on the result side. The first
        // row causes no results, so the refusal is raised as the second row
        // starts, and the sender offers cells back to back throughout.
        configure(6'd32, 10'd2);
        pattern = PAT_CHECKER;
        tx_lazy = 1'b0;
        rx_lazy = 1'b0;
        feed_rows(MAX_W, 0, 1);
        hold_req = 1'b1;
        feed_rows(MAX_W, 1, 1);

        // Random part: small grids of random size, each phase waiting for
        // the block to drain before the sizes are rewritten.
        while (items_sent < ITEM_GOAL) begin
            w = $urandom_range(2, 9);
            h = $urandom_range(2, 9);
            configure(WCFG_W'(w), HCFG_W'(h));
            repeat ($urandom_range(1, 2)) begin
                run_grid(w, h);
            end
        end

        settle();

        $display("covered %0d cells over %0d register writes, widths 2 to 32, heights 2 to 1023",
                 items_sent, reg_writes);
        $display("checked %0d filled-map and %0d pooled-map cells, %0d diagonal gaps filled",
                 filled_checked, pooled_checked, fills_seen);

        if (fail_count == 0) begin
            $display("occupancy_grid_gap_fill_and_pool regression: pass");
        end else begin
            $display("occupancy_grid_gap_fill_and_pool regression: fail");
        end
        $finish;
    end

endmodule
